// ===== src/fuv_pkg.sv =====
// fuv_pkg: shared types, codes and crc byte functions for the firmware upgrade verifier
// no dependencies

package fuv_pkg;

    localparam int PACKET_BYTES_DEF = 256;
    localparam int SECTOR_BYTES_DEF = 4096;

    localparam logic [2:0] OP_REQUEST  = 3'd0;
    localparam logic [2:0] OP_READY    = 3'd1;
    localparam logic [2:0] OP_DATA     = 3'd2;
    localparam logic [2:0] OP_CHECKSUM = 3'd3;
    localparam logic [2:0] OP_ABORT    = 3'd4;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_NOT_READY = 3'd1,
        ERR_RELAY     = 3'd2,
        ERR_WRITE     = 3'd3,
        ERR_PKT_CRC   = 3'd4,
        ERR_FILE_CRC  = 3'd5,
        ERR_MARKER    = 3'd6
    } err_t;

    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] packet_check;
        logic [15:0] packet_number;
        logic [31:0] file_check;
        logic [31:0] file_length;
        logic [7:0]  source_address;
        logic        backup_erased;
        logic        relays_open;
        logic        flash_ok;
        logic        marker_ok;
    } fuv_in_t;

    typedef struct packed {
        logic [1:0]  reply_step;
        logic [7:0]  host_address;
        logic        success;
        logic [2:0]  error_code;
        logic [31:0] running_check;
        logic [31:0] byte_total;
    } fuv_out_t;

    typedef struct packed {
        logic     valid;
        fuv_out_t data;
    } fuv_res_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC16_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = {1'b0, c[31:1]} ^ CRC32_POLY;
            end else begin
                c = {1'b0, c[31:1]};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/fuv_in_stage.sv =====
// fuv_in_stage: input word register in front of the session logic
// depends on fuv_pkg

module fuv_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fuv_pkg::fuv_in_t s_data,
    input  logic            take,
    output logic            item_valid,
    output fuv_pkg::fuv_in_t item
);
    import fuv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    fuv_in_t data_reg;
    logic    load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ===== src/fuv_core.sv =====
// fuv_core: session state, packet crc-16/crc-32 byte update and step decisions
// depends on fuv_pkg

module fuv_core #(
    parameter int PACKET_BYTES = fuv_pkg::PACKET_BYTES_DEF,
    parameter int SECTOR_BYTES = fuv_pkg::SECTOR_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             go,
    input  fuv_pkg::fuv_in_t item,
    output fuv_pkg::fuv_res_t res
);
    import fuv_pkg::*;

    localparam int CNT_W = $clog2(PACKET_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PACKET_BYTES);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [32:0] SECTOR_EXT = 33'(SECTOR_BYTES);

    logic [15:0]      final_pkt_reg;
    logic [2:0]       prev_step_reg, prev_step_next;
    logic [15:0]      pkt16_reg, pkt16_next;
    logic [31:0]      pkt32_reg, pkt32_next;
    logic [31:0]      commit_reg, commit_next;
    logic [31:0]      total_reg, total_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [15:0]      base16, upd16;
    logic [31:0]      base32, upd32;
    logic [CNT_W-1:0] upd_cnt, accepted;
    logic             in_range, pkt_pass, act;
    logic [32:0]      upper;
    err_t             err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            final_pkt_reg <= '0;
        end else if (cfg_wr_en) begin
            final_pkt_reg <= cfg_wr_data;
        end
    end

    // byte datapath
    assign base16   = (count_reg == '0) ? 16'h0000 : pkt16_reg;
    assign base32   = (count_reg == '0) ? commit_reg : pkt32_reg;
    assign in_range = count_reg < CNT_FULL;
    assign upd16    = in_range ? crc16_byte(base16, item.data_byte) : base16;
    assign upd32    = in_range ? crc32_byte(base32, item.data_byte) : base32;
    assign upd_cnt  = in_range ? count_reg + CNT_ONE : CNT_OVER;
    assign accepted = (upd_cnt > CNT_FULL) ? CNT_FULL : upd_cnt;
    assign pkt_pass = (upd_cnt <= CNT_FULL) && (item.packet_check == upd16)
                      && ((upd_cnt == CNT_FULL) || (item.packet_number == final_pkt_reg));
    assign upper    = {1'b0, total_reg} + SECTOR_EXT;

    always_comb begin
        act            = 1'b0;
        res.valid      = 1'b0;
        err            = ERR_OK;
        prev_step_next = prev_step_reg;
        pkt16_next     = pkt16_reg;
        pkt32_next     = pkt32_reg;
        commit_next    = commit_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        if (go && (item.opcode inside {[OP_REQUEST:OP_ABORT]})
            && (item.opcode >= prev_step_reg)) begin
            act            = 1'b1;
            prev_step_next = item.opcode;
        end
        if (act) begin
            case (item.opcode)
                OP_REQUEST: begin
                    commit_next = CRC32_INIT;
                    total_next  = '0;
                    res.valid   = 1'b1;
                end
                OP_READY: begin
                    res.valid = 1'b1;
                    if (!item.backup_erased) begin
                        err = ERR_NOT_READY;
                    end else if (!item.relays_open) begin
                        err = ERR_RELAY;
                    end else begin
                        commit_next = CRC32_INIT;
                        total_next  = '0;
                    end
                end
                OP_DATA: begin
                    pkt16_next = upd16;
                    pkt32_next = upd32;
                    count_next = upd_cnt;
                    if (item.last_byte) begin
                        res.valid  = 1'b1;
                        total_next = total_reg + 32'(accepted);
                        if (pkt_pass) begin
                            commit_next = upd32;
                            if (!item.flash_ok) begin
                                err = ERR_WRITE;
                            end
                        end else begin
                            err = ERR_PKT_CRC;
                        end
                    end
                end
                OP_CHECKSUM: begin
                    res.valid = 1'b1;
                    if (~commit_reg == item.file_check) begin
                        if ((item.file_length > total_reg)
                            && ({1'b0, item.file_length} <= upper)) begin
                            total_next = item.file_length;
                        end
                        if (!item.marker_ok) begin
                            err = ERR_MARKER;
                        end
                    end else begin
                        err = ERR_FILE_CRC;
                    end
                end
                default: begin
                    prev_step_next = OP_REQUEST;
                end
            endcase
            // every step except a data byte that is not the last drops the packet
            if (!((item.opcode == OP_DATA) && !item.last_byte)) begin
                count_next = '0;
                pkt16_next = '0;
                pkt32_next = commit_next;
            end
        end
        res.data.reply_step    = item.opcode[1:0];
        res.data.host_address  = item.source_address;
        res.data.success       = (err == ERR_OK);
        res.data.error_code    = err;
        res.data.running_check = commit_next;
        res.data.byte_total    = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_step_reg <= OP_REQUEST;
            pkt16_reg     <= '0;
            pkt32_reg     <= CRC32_INIT;
            commit_reg    <= CRC32_INIT;
            total_reg     <= '0;
            count_reg     <= '0;
        end else begin
            prev_step_reg <= prev_step_next;
            pkt16_reg     <= pkt16_next;
            pkt32_reg     <= pkt32_next;
            commit_reg    <= commit_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== src/fuv_out_stage.sv =====
// fuv_out_stage: result word register toward the acknowledge channel
// depends on fuv_pkg

module fuv_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fuv_pkg::fuv_res_t res,
    output logic              busy,
    output logic              m_valid,
    input  logic              m_ready,
    output fuv_pkg::fuv_out_t m_data
);
    import fuv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    fuv_out_t data_reg;
    logic     fill;

    assign fill       = load && res.valid;
    assign valid_next = fill ? 1'b1 : ((valid_reg && m_ready) ? 1'b0 : valid_reg);
    assign busy       = valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill) begin
            data_reg <= res.data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/firmware_upgrade_verifier_top.sv =====
// firmware_upgrade_verifier_top: upgrade session checker, one word per unstalled cycle
// an accepted word is held in the input register, then its acknowledge is registered
// throughput: one word per unstalled cycle; state update is one pass of crc byte logic
// reset: synchronous active-low aresetn clears session state, crc accumulators,
// totals, the final packet number and the valid flags of both word registers
// depends on fuv_pkg, fuv_in_stage, fuv_core, fuv_out_stage

module firmware_upgrade_verifier_top #(
    parameter int PACKET_BYTES = fuv_pkg::PACKET_BYTES_DEF,
    parameter int SECTOR_BYTES = fuv_pkg::SECTOR_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  fuv_pkg::fuv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fuv_pkg::fuv_out_t m_data
);
    import fuv_pkg::*;

    logic     item_valid;
    fuv_in_t  item;
    logic     out_busy;
    logic     go;
    fuv_res_t res;

    assign go = item_valid && !out_busy;

    fuv_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (go),
        .item_valid (item_valid),
        .item       (item)
    );

    fuv_core #(
        .PACKET_BYTES (PACKET_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (go),
        .item        (item),
        .res         (res)
    );

    fuv_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (go),
        .res     (res),
        .busy    (out_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !go |=> item_valid)
        else $error("stalled word dropped");

    a_ack_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.success == (m_data.error_code == ERR_OK)))
        else $error("success flag disagrees with error code");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && item_valid |=> item_valid && $stable(item))
        else $error("input register moved while output stalled");

endmodule
